// ===== design/pcx_rle_scanline_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// PCX scan line decoder assertion macros
// Shared property wrappers for the decoder's checker, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef PCX_RLE_SCANLINE_DECODER_ASSERT_SVH
`define PCX_RLE_SCANLINE_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCXD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCXD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/pcxd_pkg.sv =====
// ----------------------------------------------------------------------------
// PCX scan line decoder package
// Sequencer states, register indexes, reset values and coding constants.
// ----------------------------------------------------------------------------
package pcxd_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_ROW,
		ST_MUL_COL,
		ST_SUM,
		ST_EMIT
	} pcxd_state_t;

	localparam logic [2:0] REG_LINE_BYTES   = 3'd0;
	localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd1;
	localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd2;
	localparam logic [2:0] REG_PLANE_COUNT  = 3'd3;
	localparam logic [2:0] REG_ROW_PITCH    = 3'd4;

	localparam logic [15:0] RST_LINE_BYTES   = 16'd320;
	localparam logic [15:0] RST_IMAGE_WIDTH  = 16'd320;
	localparam logic [15:0] RST_IMAGE_HEIGHT = 16'd200;
	localparam logic [2:0]  RST_PLANE_COUNT  = 3'd1;
	localparam logic [17:0] RST_ROW_PITCH    = 18'd320;

	localparam logic [7:0] RUN_MARK   = 8'hC0;
	localparam logic [7:0] COUNT_MASK = 8'h3F;

	localparam int unsigned MUL_A_W = 16;
	localparam int unsigned MUL_B_W = 18;
	localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

endpackage

// ===== design/pcxd_mul.sv =====
// ----------------------------------------------------------------------------
// PCX scan line decoder shared multiplier
// One registered 16 by 18 bit unsigned multiplier, loaded when enabled and
// used in turn for the row base and the column offset.
// ----------------------------------------------------------------------------
module pcxd_mul (
	input  logic                          clk,
	input  logic                          en,
	input  logic [pcxd_pkg::MUL_A_W-1:0]  a,
	input  logic [pcxd_pkg::MUL_B_W-1:0]  b,
	output logic [pcxd_pkg::MUL_P_W-1:0]  p_q
);
	import pcxd_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= MUL_P_W'(a) * MUL_P_W'(b);
		end
	end

endmodule

// ===== design/pcx_rle_scanline_decoder.sv =====
// ----------------------------------------------------------------------------
// PCX run-length scan line decoder
// Expands an 8 bit PCX run-length coded image body into addressed bytes.
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   in_byte
//  out      output     out_valid / out_ready pixel_value, pixel_address,
//                                            is_padding, run_last, image_done
//  cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A run count byte is taken while idle and emits nothing. A literal or run
// value byte is taken, its address formed in ST_MUL_ROW, ST_MUL_COL and ST_SUM
// (two passes through the shared multiplier and one add), then one result beat
// per cycle follows; output stalls hold the current beat. The input is not
// ready until the last result beat of a byte has gone. Reset is asynchronous.
// ----------------------------------------------------------------------------
module pcx_rle_scanline_decoder #(
	parameter int unsigned ADDR_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  pixel_value,
	output logic [31:0] pixel_address,
	output logic        is_padding,
	output logic        run_last,
	output logic        image_done,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [17:0] cfg_data
);
	import pcxd_pkg::*;

	pcxd_state_t state_q, state_d;

	logic [15:0] line_bytes_q, image_width_q, image_height_q;
	logic [2:0]  plane_count_q;
	logic [17:0] row_pitch_q;

	logic        await_q, finished_q;
	logic [5:0]  pending_q, remain_q;
	logic [15:0] column_q, row_q;
	logic [1:0]  plane_q;
	logic [7:0]  value_q;
	logic [ADDR_BITS-1:0] base_q, addr_q;

	logic                 mul_en;
	logic [MUL_A_W-1:0]   mul_a;
	logic [MUL_B_W-1:0]   mul_b;
	logic [MUL_P_W-1:0]   mul_p;

	logic [2:0]  planes_eff;
	logic [15:0] col_inc;
	logic [1:0]  plane_inc;
	logic        line_end, plane_wrap, last_row;
	logic        in_fire, out_fire, is_run;
	logic [5:0]  run_count;

	pcxd_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (mul_p)
	);

	always_comb begin
		if (plane_count_q == 3'd0) begin
			planes_eff = 3'd1;
		end else if (plane_count_q > 3'd4) begin
			planes_eff = 3'd4;
		end else begin
			planes_eff = plane_count_q;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_EMIT);
	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;
	assign is_run    = ((in_byte & RUN_MARK) == RUN_MARK);
	assign run_count = 6'(in_byte & COUNT_MASK);

	assign col_inc    = (column_q != 16'hFFFF) ? column_q + 16'd1 : column_q;
	assign plane_inc  = plane_q + 2'd1;
	assign line_end   = (col_inc >= line_bytes_q);
	assign plane_wrap = (plane_inc == 2'd0) || ({1'b0, plane_inc} >= planes_eff);
	assign last_row   = ({1'b0, row_q} + 17'd1) >= {1'b0, image_height_q};

	assign pixel_value   = value_q;
	assign pixel_address = 32'(addr_q);
	assign is_padding    = (column_q >= image_width_q) || (column_q >= line_bytes_q);
	assign run_last      = (remain_q == 6'd1);
	assign image_done    = run_last && line_end && plane_wrap && last_row;

	always_comb begin
		state_d = state_q;
		mul_en  = 1'b0;
		mul_a   = row_q;
		mul_b   = row_pitch_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && !finished_q) begin
					if (await_q) begin
						if (pending_q != 6'd0) begin
							state_d = ST_MUL_ROW;
						end
					end else if (!is_run) begin
						state_d = ST_MUL_ROW;
					end
				end
			end
			ST_MUL_ROW: begin
				mul_en  = 1'b1;
				state_d = ST_MUL_COL;
			end
			ST_MUL_COL: begin
				mul_en  = 1'b1;
				mul_a   = column_q;
				mul_b   = MUL_B_W'(planes_eff);
				state_d = ST_SUM;
			end
			ST_SUM: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_fire && run_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_bytes_q   <= RST_LINE_BYTES;
			image_width_q  <= RST_IMAGE_WIDTH;
			image_height_q <= RST_IMAGE_HEIGHT;
			plane_count_q  <= RST_PLANE_COUNT;
			row_pitch_q    <= RST_ROW_PITCH;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LINE_BYTES:   line_bytes_q   <= cfg_data[15:0];
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[15:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[15:0];
				REG_PLANE_COUNT:  plane_count_q  <= cfg_data[2:0];
				REG_ROW_PITCH:    row_pitch_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			await_q    <= 1'b0;
			pending_q  <= 6'd0;
			remain_q   <= 6'd0;
			column_q   <= 16'd0;
			plane_q    <= 2'd0;
			row_q      <= 16'd0;
			finished_q <= 1'b0;
		end else begin
			if (in_fire && !finished_q) begin
				if (await_q) begin
					await_q   <= 1'b0;
					pending_q <= 6'd0;
					remain_q  <= pending_q;
				end else if (is_run) begin
					await_q   <= 1'b1;
					pending_q <= run_count;
				end else begin
					remain_q  <= 6'd1;
				end
			end
			if (out_fire) begin
				remain_q <= remain_q - 6'd1;
				if (run_last && line_end) begin
					column_q <= 16'd0;
					if (plane_wrap) begin
						plane_q <= 2'd0;
						if (last_row) begin
							finished_q <= 1'b1;
						end else begin
							row_q <= row_q + 16'd1;
						end
					end else begin
						plane_q <= plane_inc;
					end
				end else begin
					column_q <= col_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			value_q <= in_byte;
		end
		if (state_q == ST_MUL_COL) begin
			base_q <= mul_p[ADDR_BITS-1:0];
		end
		if (state_q == ST_SUM) begin
			addr_q <= base_q + ADDR_BITS'(mul_p[MUL_B_W-1:0]) + ADDR_BITS'(plane_q);
		end else if (out_fire && column_q != 16'hFFFF) begin
			addr_q <= addr_q + ADDR_BITS'(planes_eff);
		end
	end

endmodule

// ===== design/pcxd_checker.sv =====
// ----------------------------------------------------------------------------
// PCX scan line decoder checker
// Port-level properties of the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "pcx_rle_scanline_decoder_assert.svh"

module pcxd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  pixel_value,
	input logic [31:0] pixel_address,
	input logic        run_last,
	input logic        image_done
);

	`PCXD_ASSERT_SAME(a_one_item, out_valid, !in_ready, "Input ready while a result beat is pending.")

	`PCXD_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !run_last, out_valid, "Run broke off before its last beat.")

	`PCXD_ASSERT_NEXT(a_run_value, out_valid && out_ready && !run_last, pixel_value == $past(pixel_value), "Value changed within a run.")

	`PCXD_ASSERT_SAME(a_done_last, out_valid && image_done, run_last, "Image end flagged on a beat that is not the last of its byte.")

	`PCXD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_address), "Stalled result beat was dropped or changed.")

endmodule

bind pcx_rle_scanline_decoder pcxd_checker u_pcxd_checker (.*);
